/* rtl/rps_pkg.sv */
package rps_pkg;

	// operation codes carried in s_tuser (code 3 is served as a read)
	localparam logic [1:0] OP_STEP    = 2'd0;
	localparam logic [1:0] OP_READ    = 2'd1;
	localparam logic [1:0] OP_RESTART = 2'd2;

	// result status codes carried in m_tuser
	localparam logic [2:0] ST_STEP_DONE      = 3'd0;
	localparam logic [2:0] ST_STEP_FULL      = 3'd1;
	localparam logic [2:0] ST_READ_OK        = 3'd2;
	localparam logic [2:0] ST_READ_UNWRITTEN = 3'd3;
	localparam logic [2:0] ST_RESTARTED      = 3'd4;

	// fixed field widths
	localparam int WORD_W  = 32;
	localparam int INDEX_W = 21;
	localparam int COUNT_W = 22;
	localparam int STAT_W  = 3;
	localparam int OP_W    = 2;

	// divider runs one quotient bit per cycle
	localparam int DIV_STEPS = WORD_W;
	localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

	// reset value of element_count
	localparam logic [COUNT_W-1:0] COUNT_RESET = 22'd2097152;

	// commands from controller to datapath
	typedef struct packed {
		logic              load_item;
		logic              div_start;
		logic              rd_j;
		logic              rd_idx;
		logic              wr_pos;
		logic              wr_j;
		logic              clr_pos;
		logic              fin;
		logic [STAT_W-1:0] result;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic is_step;
		logic is_restart;
		logic step_ok;
		logic read_ok;
		logic div_busy;
		logic out_free;
	} stat_t;

endpackage

/* rtl/rps_ram.sv */
module rps_ram #(
	parameter int WIDTH = 21,
	parameter int DEPTH = 2097152
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/rps_datapath.sv */
module rps_datapath #(
	parameter int MAX_ENTRIES = 2097152
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rps_pkg::cmd_t                 cmd,
	output rps_pkg::stat_t                stat,
	input  logic [rps_pkg::COUNT_W-1:0]   element_count,
	input  logic [rps_pkg::OP_W-1:0]      in_operation,
	input  logic [rps_pkg::WORD_W-1:0]    in_random_word,
	input  logic [rps_pkg::INDEX_W-1:0]   in_read_index,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rps_pkg::INDEX_W-1:0]   out_entry_value,
	output logic [rps_pkg::STAT_W-1:0]    out_status,
	output logic [rps_pkg::COUNT_W-1:0]   out_steps_done
);

	localparam int AW = $clog2(MAX_ENTRIES);
	localparam int PW = $clog2(MAX_ENTRIES + 1);
	localparam int CW = (PW > rps_pkg::COUNT_W) ? PW : rps_pkg::COUNT_W;

	logic [rps_pkg::OP_W-1:0]    op_q;
	logic [rps_pkg::WORD_W-1:0]  word_q;
	logic [rps_pkg::INDEX_W-1:0] idx_q;
	logic [PW-1:0]               pos_q;

	logic [PW-1:0]               rem_q;
	logic [PW-1:0]               dvs_q;
	logic [rps_pkg::WORD_W-1:0]  dvd_q;
	logic [rps_pkg::DCNT_W-1:0]  dcnt_q;
	logic [PW:0]                 trial;
	logic [PW:0]                 diff;

	logic [CW-1:0] pos_c;
	logic [CW-1:0] ec_c;
	logic [CW-1:0] max_c;
	logic [CW-1:0] idx_c;
	logic [CW-1:0] rd_c;

	logic [AW-1:0] j_a;
	logic [AW-1:0] pos_a;
	logic [AW-1:0] ram_waddr;
	logic [AW-1:0] ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [AW-1:0] ram_rdata;

	logic                        out_valid_q;
	logic [rps_pkg::INDEX_W-1:0] entry_q;
	logic [rps_pkg::STAT_W-1:0]  status_q;
	logic [rps_pkg::COUNT_W-1:0] steps_q;

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q   <= in_operation;
			word_q <= in_random_word;
			idx_q  <= in_read_index;
		end
	end

	// shuffle position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (cmd.clr_pos) begin
			pos_q <= '0;
		end else if (cmd.wr_j) begin
			pos_q <= pos_q + PW'(1);
		end
	end

	// range checks
	assign pos_c = CW'(pos_q);
	assign ec_c  = CW'(element_count);
	assign max_c = CW'(MAX_ENTRIES);
	assign idx_c = CW'(idx_q);

	assign stat.is_step    = (op_q == rps_pkg::OP_STEP);
	assign stat.is_restart = (op_q == rps_pkg::OP_RESTART);
	assign stat.step_ok    = (pos_c < ec_c) && (pos_c < max_c);
	assign stat.read_ok    = (idx_c < pos_c) && (idx_c < max_c);
	assign stat.div_busy   = (dcnt_q != '0);
	assign stat.out_free   = !out_valid_q || out_ready;

	// restoring divider, one bit per cycle, remainder only
	assign trial = {rem_q, dvd_q[rps_pkg::WORD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (cmd.div_start) begin
			dcnt_q <= rps_pkg::DCNT_W'(rps_pkg::DIV_STEPS);
		end else if (dcnt_q != '0) begin
			dcnt_q <= dcnt_q - rps_pkg::DCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= '0;
			dvd_q <= word_q;
			dvs_q <= pos_q + PW'(1);
		end else if (dcnt_q != '0) begin
			dvd_q <= {dvd_q[rps_pkg::WORD_W-2:0], 1'b0};
			if (trial >= {1'b0, dvs_q}) begin
				rem_q <= diff[PW-1:0];
			end else begin
				rem_q <= trial[PW-1:0];
			end
		end
	end

	// table access: read t[j] or t[idx], write t[pos] then t[j]
	assign j_a       = rem_q[AW-1:0];
	assign pos_a     = pos_q[AW-1:0];
	assign ram_raddr = cmd.rd_j ? j_a : idx_c[AW-1:0];
	assign ram_waddr = cmd.wr_j ? j_a : pos_a;
	assign ram_wdata = cmd.wr_j ? pos_a : ram_rdata;

	rps_ram #(
		.WIDTH (AW),
		.DEPTH (MAX_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (cmd.wr_pos | cmd.wr_j),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.rd_j | cmd.rd_idx),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_c = CW'(ram_rdata);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			status_q <= cmd.result;
			steps_q  <= pos_c[rps_pkg::COUNT_W-1:0];
			if (cmd.result == rps_pkg::ST_READ_OK) begin
				entry_q <= rd_c[rps_pkg::INDEX_W-1:0];
			end else begin
				entry_q <= '0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign out_entry_value = entry_q;
	assign out_status      = status_q;
	assign out_steps_done  = steps_q;

endmodule

/* rtl/rps_ctrl.sv */
module rps_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  rps_pkg::stat_t stat,
	output rps_pkg::cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_DIV,
		S_RD,
		S_WRP,
		S_WRJ,
		S_FIN
	} state_t;

	state_t                      state_q;
	state_t                      state_d;
	logic [rps_pkg::STAT_W-1:0]  res_q;
	logic [rps_pkg::STAT_W-1:0]  res_d;

	// next state and result code
	always_comb begin
		state_d = state_q;
		res_d   = res_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (stat.is_restart) begin
					res_d   = rps_pkg::ST_RESTARTED;
					state_d = S_FIN;
				end else if (stat.is_step) begin
					if (stat.step_ok) begin
						res_d   = rps_pkg::ST_STEP_DONE;
						state_d = S_DIV;
					end else begin
						res_d   = rps_pkg::ST_STEP_FULL;
						state_d = S_FIN;
					end
				end else if (stat.read_ok) begin
					res_d   = rps_pkg::ST_READ_OK;
					state_d = S_RD;
				end else begin
					res_d   = rps_pkg::ST_READ_UNWRITTEN;
					state_d = S_FIN;
				end
			end
			S_DIV: begin
				if (!stat.div_busy) begin
					state_d = S_RD;
				end
			end
			S_RD: begin
				state_d = stat.is_step ? S_WRP : S_FIN;
			end
			S_WRP: begin
				state_d = S_WRJ;
			end
			S_WRJ: begin
				state_d = S_FIN;
			end
			S_FIN: begin
				if (stat.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and registered result code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_q   <= rps_pkg::ST_STEP_DONE;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
		end
	end

	// command decode
	assign in_ready      = (state_q == S_IDLE);
	assign cmd.load_item = (state_q == S_IDLE) && in_valid;
	assign cmd.clr_pos   = (state_q == S_DECODE) && stat.is_restart;
	assign cmd.div_start = (state_q == S_DECODE) && !stat.is_restart && stat.is_step
		&& stat.step_ok;
	assign cmd.rd_j      = (state_q == S_RD) && stat.is_step;
	assign cmd.rd_idx    = (state_q == S_RD) && !stat.is_step;
	assign cmd.wr_pos    = (state_q == S_WRP);
	assign cmd.wr_j      = (state_q == S_WRJ);
	assign cmd.fin       = (state_q == S_FIN) && stat.out_free;
	assign cmd.result    = res_q;

endmodule

/* rtl/random_permutation_shuffler.sv */
// Random permutation shuffler: builds a permutation of 0..count-1 in an
// on-chip table with the forward Fisher-Yates shuffle.
// Input item on s_*: s_tuser is the operation (step, read, restart),
// s_tdata holds the random word and the read index. Each item gives one
// result item on m_*: m_tuser is the status, m_tdata holds the entry read
// and the number of steps done since the last restart.
// The user must set element_count through the APB port at address 0
// while idle; the block does not enforce this. A shuffle step runs
// decode, the bit-serial remainder unit, one table read, two table
// writes and one output load; a read runs decode, one table read and the
// output load; a restart or an ignored step runs decode and the output load.
// One item is worked on at a time; the next is taken back in idle.
// s_tready drops while an item is being worked on; a finished result sits
// in the output register, and if m_tready is low the next result waits in
// its last state until the register is free.
// Reset clears the position and the output valid; element_count returns to
// 2097152. The table is not cleared: reads at or above the position are
// reported as unwritten.
module random_permutation_shuffler #(
	parameter int MAX_ENTRIES = 2097152
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // random_word[31:0], read_index[52:32], zero pad
	input  logic [1:0]  s_tuser,   // operation[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // entry_value[20:0], steps_done[42:21], zero pad
	output logic [2:0]  m_tuser    // status[2:0]
);

	localparam logic [1:0] ADDR_ELEMENT_COUNT = 2'd0;

	logic [rps_pkg::COUNT_W-1:0] count_q;
	rps_pkg::cmd_t               cmd;
	rps_pkg::stat_t              stat;
	logic [rps_pkg::INDEX_W-1:0] entry_value;
	logic [rps_pkg::COUNT_W-1:0] steps_done;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= rps_pkg::COUNT_RESET;
		end else if (psel && penable && pwrite && pready
			&& paddr == ADDR_ELEMENT_COUNT) begin
			count_q <= pwdata[rps_pkg::COUNT_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_ELEMENT_COUNT) ? 32'(count_q) : 32'd0;

	rps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rps_datapath #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.element_count   (count_q),
		.in_operation    (s_tuser),
		.in_random_word  (s_tdata[31:0]),
		.in_read_index   (s_tdata[52:32]),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.out_entry_value (entry_value),
		.out_status      (m_tuser),
		.out_steps_done  (steps_done)
	);

	assign m_tdata = {5'd0, steps_done, entry_value};

	// no new item is taken right after one was accepted
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("item accepted while busy");

	// a restart always reports zero steps
	a_restart_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == rps_pkg::ST_RESTARTED |-> m_tdata[42:21] == 22'd0)
		else $error("restart result with nonzero steps");

	// only a successful read carries an entry
	a_entry_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != rps_pkg::ST_READ_OK |-> m_tdata[20:0] == 21'd0)
		else $error("nonzero entry on a result that is not a read");

	// steps never run past the table size
	a_steps_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> 64'(m_tdata[42:21]) <= 64'(MAX_ENTRIES))
		else $error("steps done beyond table size");

endmodule
